>>> rtl/redm_pkg.sv
// shared types and constants for the red/ecn marker
// command and status bundles between controller and datapath
package redm_pkg;

  localparam int AVG_FRAC_BITS = 16;
  localparam int AVG_W         = 27;
  localparam int CNT_W         = 17;
  localparam int Q_W           = 11;

  localparam logic [Q_W-1:0]   MAX_QUEUE = 11'd1024;
  localparam logic [CNT_W-1:0] COUNT_MAX = 17'd65535;
  localparam logic [CNT_W-1:0] COUNT_NONE = '1;

  localparam logic [1:0] VERDICT_SEND = 2'd0;
  localparam logic [1:0] VERDICT_MARK = 2'd1;
  localparam logic [1:0] VERDICT_DROP = 2'd2;

  localparam logic [1:0] CODE_NOT_ECT = 2'd0;
  localparam logic [1:0] CODE_CE      = 2'd3;

  localparam logic [2:0] REG_MIN_TH   = 3'd0;
  localparam logic [2:0] REG_MAX_TH   = 3'd1;
  localparam logic [2:0] REG_MAX_PROB = 3'd2;
  localparam logic [2:0] REG_W_SHIFT  = 3'd3;
  localparam logic [2:0] REG_CAPACITY = 3'd4;

  typedef struct packed {
    logic load;
    logic pend_mark;
    logic avg_move;
    logic decay;
    logic eval;
    logic mul;
    logic div_init;
    logic div_step;
    logic prod;
    logic rmul;
    logic cmp;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic       pending;
    logic       q_zero;
    logic [7:0] idle;
    logic       band;
  } sts_t;

endpackage

>>> rtl/red_ecn_marker_core.sv
// red/ecn marker: one verdict per packet, registered with m_tvalid; a pending mark goes
// straight to it, a non-empty queue is averaged then judged, an empty queue first decays
// once per idle slot, and the marking band adds a multiply and a 16-step serial divide.
// one packet at a time; the next transfer is taken the cycle after the result is registered,
// also while that result waits on the output.
// rst is synchronous: config returns to 5/50/6554/9/100, average 0, count -1, flag 0.
// depends on redm_pkg, redm_ctrl and redm_datapath
module red_ecn_marker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // queue_length, ecn_codepoint, idle_slots, random_value
  input  logic        s_tuser,   // ecn_ipv4
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // verdict, set_ce
);
  import redm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  redm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  redm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> rtl/redm_ctrl.sv
// sequencing state machine for the red/ecn marker
// depends on redm_pkg; drives redm_datapath through cmd_t
module redm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  redm_pkg::sts_t sts,
  output redm_pkg::cmd_t cmd
);
  import redm_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_START = 11'b00000000010,
    S_DECAY = 11'b00000000100,
    S_EVAL  = 11'b00000001000,
    S_MUL   = 11'b00000010000,
    S_DINIT = 11'b00000100000,
    S_DIV   = 11'b00001000000,
    S_PROD  = 11'b00010000000,
    S_RMUL  = 11'b00100000000,
    S_CMP   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t     state, state_next;
  logic [7:0] cnt, cnt_next;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        priority if (sts.pending) begin
          cmd.pend_mark = 1'b1;
          state_next    = S_DONE;
        end else if (sts.q_zero) begin
          cnt_next   = sts.idle;
          state_next = S_DECAY;
        end else begin
          cmd.avg_move = 1'b1;
          state_next   = S_EVAL;
        end
      end
      S_DECAY: begin
        if (cnt == 8'd0) begin
          state_next = S_EVAL;
        end else begin
          cmd.decay = 1'b1;
          cnt_next  = cnt - 8'd1;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.band ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = 8'd15;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 8'd1;
        if (cnt == 8'd0) state_next = S_PROD;
      end
      S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = S_RMUL;
      end
      S_RMUL: begin
        cmd.rmul   = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= 8'd0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.push) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

>>> rtl/redm_datapath.sv
// config registers, average/count state and arithmetic for the red/ecn marker
// depends on redm_pkg; steered by redm_ctrl through cmd_t
module redm_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_addr,
  input  logic [15:0]         cfg_wdata,
  input  logic [39:0]         s_tdata,
  input  logic                s_tuser,
  output logic [7:0]          m_tdata,
  input  redm_pkg::cmd_t      cmd,
  output redm_pkg::sts_t      sts
);
  import redm_pkg::*;

  // configuration
  logic [10:0] min_th, max_th, capacity;
  logic [15:0] max_prob;
  logic [3:0]  w_shift;

  // state
  logic [AVG_W-1:0] avg;
  logic [CNT_W-1:0] count;
  logic             mark_flag;

  // latched item
  logic [Q_W-1:0] q;
  logic           ipv4;
  logic [1:0]     code;
  logic [7:0]     idle;
  logic [15:0]    rnd;

  // work registers
  logic [41:0] prod;
  logic [10:0] rem;
  logic [15:0] qsh;
  logic [31:0] prod2;
  logic [32:0] rprod;
  logic        nonpos;
  logic [1:0]  res_verdict;
  logic        res_ce;
  logic [1:0]  out_verdict;
  logic        out_ce;

  logic [Q_W-1:0]   q_in;
  logic [10:0]      cap;
  logic [AVG_W-1:0] lo, hi, target;
  logic             capable, drop, in_band;
  logic [10:0]      diff;
  logic [11:0]      trial;
  logic             trial_ge;
  logic [16:0]      dval;
  logic             mark_now;

  assign q_in = (s_tdata[10:0] > MAX_QUEUE) ? MAX_QUEUE : s_tdata[10:0];
  assign cap     = (capacity > max_th) ? capacity : max_th;
  assign lo      = {5'd0, min_th, 11'd0} << 5;
  assign hi      = {5'd0, max_th, 11'd0} << 5;
  assign target  = {q, 16'd0};
  assign capable = ipv4 && (code != CODE_NOT_ECT);
  assign drop    = (q >= cap);
  assign in_band = (lo <= avg) && (avg < hi);
  assign diff    = max_th - min_th;
  assign trial   = {rem, qsh[15]};
  assign trial_ge = (trial >= {1'b0, diff});
  assign dval    = 17'h10000 - {1'b0, prod2[15:0]};
  assign mark_now = nonpos || (rprod < {1'b0, qsh, 16'd0});

  assign sts.pending = capable && mark_flag && (code != CODE_CE);
  assign sts.q_zero  = (q == '0);
  assign sts.idle    = idle;
  assign sts.band    = capable && !drop && in_band;

  assign m_tdata = {5'd0, out_ce, out_verdict};

  always_ff @(posedge clk) begin
    if (rst) begin
      min_th    <= 11'd5;
      max_th    <= 11'd50;
      max_prob  <= 16'd6554;
      w_shift   <= 4'd9;
      capacity  <= 11'd100;
      avg       <= '0;
      count     <= COUNT_NONE;
      mark_flag <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_MIN_TH:   min_th   <= cfg_wdata[10:0];
          REG_MAX_TH:   max_th   <= cfg_wdata[10:0];
          REG_MAX_PROB: max_prob <= cfg_wdata;
          REG_W_SHIFT:  w_shift  <= cfg_wdata[3:0];
          REG_CAPACITY: capacity <= cfg_wdata[10:0];
          default: ;
        endcase
      end
      if (cmd.pend_mark) mark_flag <= 1'b0;
      if (cmd.avg_move) begin
        if (target >= avg) avg <= avg + ((target - avg) >> w_shift);
        else avg <= avg - ((avg - target) >> w_shift);
      end
      if (cmd.decay) avg <= avg - (avg >> w_shift);
      if (cmd.eval) begin
        priority if (drop) count <= '0;
        else if (!capable) count <= COUNT_NONE;
        else if (in_band) begin
          if (count != COUNT_MAX) count <= count + 17'd1;
        end else if (avg >= hi) begin
          count <= '0;
          if (code == CODE_CE) mark_flag <= 1'b1;
        end else count <= COUNT_NONE;
      end
      if (cmd.cmp && mark_now) begin
        count <= '0;
        if (code == CODE_CE) mark_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q    <= q_in;
      ipv4 <= s_tuser;
      code <= s_tdata[12:11];
      idle <= s_tdata[20:13];
      rnd  <= s_tdata[36:21];
    end
    if (cmd.pend_mark) begin
      res_verdict <= VERDICT_MARK;
      res_ce      <= 1'b1;
    end
    if (cmd.eval) begin
      priority if (drop) begin
        res_verdict <= VERDICT_DROP;
        res_ce      <= 1'b0;
      end else if (capable && !in_band && avg >= hi) begin
        res_verdict <= VERDICT_MARK;
        res_ce      <= (code != CODE_CE);
      end else begin
        res_verdict <= VERDICT_SEND;
        res_ce      <= 1'b0;
      end
    end
    if (cmd.mul) prod <= max_prob * (avg - lo);
    if (cmd.div_init) begin
      rem <= {1'b0, prod[41:32]};
      qsh <= prod[31:16];
    end
    // restoring divide, one quotient bit per step
    if (cmd.div_step) begin
      rem <= trial_ge ? 11'(trial - {1'b0, diff}) : trial[10:0];
      qsh <= {qsh[14:0], trial_ge};
    end
    if (cmd.prod) prod2 <= count[15:0] * qsh;
    if (cmd.rmul) begin
      nonpos <= (prod2[31:16] != 16'd0);
      rprod  <= rnd * dval;
    end
    if (cmd.cmp && mark_now) begin
      res_verdict <= VERDICT_MARK;
      res_ce      <= (code != CODE_CE);
    end
    if (cmd.push) begin
      out_verdict <= res_verdict;
      out_ce      <= res_ce;
    end
  end

endmodule

>>> rtl/redm_checker.sv
// port-level checks for red_ecn_marker_core
// attached to the top level by the bind below
module redm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  import redm_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transfer taken while busy");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] == VERDICT_SEND || m_tdata[1:0] == VERDICT_MARK
      || m_tdata[1:0] == VERDICT_DROP)
    else $error("bad verdict");

  a_ce_on_mark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1:0] == VERDICT_MARK)
    else $error("ce rewrite without mark");

endmodule

bind red_ecn_marker_core redm_checker u_redm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> bench/tb.sv
// testbench for red_ecn_marker_core: packet stream in, verdict stream out
// keeps its own model of the average queue length, the mark count and the pending mark
// depends on redm_pkg and the red_ecn_marker_core rtl
`timescale 1ns / 100ps

module tb;
  import redm_pkg::*;

  typedef struct packed {
    logic [1:0] verdict;
    logic       set_ce;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // queue_length, ecn_codepoint, idle_slots, random_value
  logic        s_tuser = 1'b0; // ecn_ipv4
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // verdict, set_ce

  red_ecn_marker_core DUT (.*);

  always #6 clk = ~clk;

  // model copy of registers and state
  logic [10:0] min_th, max_th, capacity;
  logic [15:0] max_prob;
  logic [3:0]  w_shift;
  longint unsigned avg_len;
  longint          mark_count;
  logic            pend_mark;

  verdict_t verdicts_due[$];
  int errors, packets, verdicts_seen, marks_seen, drops_seen;
  int idle_cycles;
  bit no_gaps, no_stalls;
  int stall_left;

  function automatic void move_average(longint unsigned q, longint unsigned idle);
    longint unsigned target;
    if (q > 0) begin
      target = q << AVG_FRAC_BITS;
      if (target >= avg_len) avg_len += (target - avg_len) >> w_shift;
      else avg_len -= (avg_len - target) >> w_shift;
    end else begin
      for (int i = 0; i < idle && avg_len != 0; i++) avg_len -= avg_len >> w_shift;
    end
  endfunction

  function automatic verdict_t judge_packet(logic [10:0] q_in, logic ipv4, logic [1:0] code,
                                            logic [7:0] idle, logic [15:0] rnd);
    verdict_t r;
    longint unsigned q, limit, lo, hi, pb;
    longint d;
    int act;
    r = '{VERDICT_SEND, 1'b0};
    q = (q_in > MAX_QUEUE) ? MAX_QUEUE : q_in;
    limit = (capacity > max_th) ? capacity : max_th;
    if (ipv4 && code != CODE_NOT_ECT) begin
      if (pend_mark && code != CODE_CE) begin
        pend_mark = 1'b0;
        r = '{VERDICT_MARK, 1'b1};
      end else begin
        act = 0;
        move_average(q, (q == 0) ? idle : 0);
        lo = longint'(min_th) << AVG_FRAC_BITS;
        hi = longint'(max_th) << AVG_FRAC_BITS;
        if (q >= limit) begin
          mark_count = 0;
          act = 2;
        end else if (lo <= avg_len && avg_len < hi) begin
          if (mark_count < 65535) mark_count++;
          pb = (longint'(max_prob) * (avg_len - lo)) / (hi - lo);
          d = 65536 - mark_count * longint'(pb);
          if (d <= 0 || longint'(rnd) * d < longint'(pb << 16)) begin
            mark_count = 0;
            act = 1;
          end
        end else if (avg_len >= hi) begin
          mark_count = 0;
          act = 1;
        end else begin
          mark_count = -1;
        end
        if (act == 2) r.verdict = VERDICT_DROP;
        else if (act == 1) begin
          r.verdict = VERDICT_MARK;
          if (code == CODE_CE) pend_mark = 1'b1;
          else r.set_ce = 1'b1;
        end
      end
    end else begin
      move_average(q, idle);
      if (q >= limit) begin
        mark_count = 0;
        r.verdict = VERDICT_DROP;
      end else begin
        mark_count = -1;
      end
    end
    return r;
  endfunction

  task automatic write_reg(logic [2:0] addr, logic [15:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (addr)
      REG_MIN_TH:   min_th   = value[10:0];
      REG_MAX_TH:   max_th   = value[10:0];
      REG_MAX_PROB: max_prob = value;
      REG_W_SHIFT:  w_shift  = value[3:0];
      REG_CAPACITY: capacity = value[10:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int mn, int mx, int prob, int sh, int cap);
    write_reg(REG_MIN_TH, mn);
    write_reg(REG_MAX_TH, mx);
    write_reg(REG_MAX_PROB, prob);
    write_reg(REG_W_SHIFT, sh);
    write_reg(REG_CAPACITY, cap);
  endtask

  // wait out every verdict, then the longest decay walk
  task automatic drain();
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic send_packet(logic [10:0] q, logic ipv4, logic [1:0] code,
                             logic [7:0] idle, logic [15:0] rnd);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tdata  <= {3'b0, rnd, idle, code, q};
    s_tuser  <= ipv4;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    verdicts_due.push_back(judge_packet(q, ipv4, code, idle, rnd));
    packets++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // random packet shaped around the thresholds, with some noise over the full range
  task automatic random_packet();
    logic [10:0] q;
    logic [7:0]  idle;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) q = $urandom_range(0, 2047);
    else if (pick < 3) q = 0;
    else q = $urandom_range(min_th, max_th + 8);
    idle = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
    send_packet(q, $urandom_range(0, 7) != 0, $urandom_range(0, 3), idle, $urandom);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        no_gaps   = ($urandom_range(0, 3) == 0);
        no_stalls = ($urandom_range(0, 3) == 0);
      end
      random_packet();
    end
    no_gaps = 1'b0;
    no_stalls = 1'b0;
    stop_sending();
    drain();
  endtask

  task automatic test_reset_values();
    send_packet(11'd0, 1'b1, 2'd1, 8'd255, 16'd0);
    send_packet(11'd2047, 1'b0, 2'd0, 8'd0, 16'hFFFF);
    send_packet(11'd1024, 1'b1, 2'd2, 8'd0, 16'd0);
    send_packet(11'd99, 1'b1, 2'd0, 8'd1, 16'd1);
    send_packet(11'd100, 1'b0, 2'd3, 8'd0, 16'd0);
    send_packet(11'd100, 1'b1, 2'd3, 8'd0, 16'd0);
    send_packet(11'd1025, 1'b1, 2'd1, 8'hAA, 16'h5555);
    stop_sending();
    drain();
  endtask

  // average jumps above the max threshold; ce packets leave a mark pending for the next ect one
  task automatic test_pending_mark();
    set_config(0, 1, 65535, 1, 1024);
    send_packet(11'd1000, 1'b1, 2'd3, 8'd0, 16'hFFFF);
    send_packet(11'd1000, 1'b1, 2'd3, 8'd0, 16'd0);
    send_packet(11'd1000, 1'b1, 2'd3, 8'd0, 16'd0);
    send_packet(11'd1000, 1'b1, 2'd1, 8'd0, 16'd0);
    send_packet(11'd1000, 1'b1, 2'd2, 8'd0, 16'd0);
    send_packet(11'd0, 1'b1, 2'd3, 8'd255, 16'd0);
    send_packet(11'd1023, 1'b1, 2'd1, 8'd0, 16'd0);
    stop_sending();
    drain();
  endtask

  task automatic test_zero_shift();
    set_config(3, 6, 40000, 0, 8);
    send_packet(11'd5, 1'b1, 2'd1, 8'd0, 16'd0);
    send_packet(11'd5, 1'b1, 2'd2, 8'd0, 16'hFFFF);
    send_packet(11'd0, 1'b1, 2'd1, 8'd1, 16'd0);
    send_packet(11'd4, 1'b1, 2'd1, 8'd0, 16'd100);
    send_packet(11'd8, 1'b1, 2'd1, 8'd0, 16'd0);
    send_packet(11'd0, 1'b0, 2'd2, 8'd1, 16'd0);
    stop_sending();
    drain();
  endtask

  task automatic test_band(int mn, int mx, int prob, int sh, int cap, int count);
    set_config(mn, mx, prob, sh, cap);
    run_random(count);
  endtask

  task automatic test_pressure();
    set_config(20, 200, 30000, 3, 300);
    for (int i = 0; i < 60; i++) begin
      random_packet();
      if (i % 20 == 19) begin
        stop_sending();
        while (verdicts_due.size() != 0) @(posedge clk);
      end
    end
    stop_sending();
    drain();
  endtask

  // result checker
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      stall_left = no_stalls ? 0 : $urandom_range(0, 10);
      verdicts_seen++;
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: verdict with none expected, actual %h", $realtime, m_tdata);
      end else begin
        want = verdicts_due.pop_front();
        if (m_tdata[1:0] == VERDICT_MARK) marks_seen++;
        if (m_tdata[1:0] == VERDICT_DROP) drops_seen++;
        if (m_tdata[1:0] !== want.verdict) begin
          errors++;
          $display("%0t: verdict expected %0d actual %0d", $realtime, want.verdict,
                   m_tdata[1:0]);
        end
        if (m_tdata[2] !== want.set_ce) begin
          errors++;
          $display("%0t: set_ce expected %0d actual %0d", $realtime, want.set_ce, m_tdata[2]);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else m_tready <= 1'b1;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    min_th = 11'd5;
    max_th = 11'd50;
    max_prob = 16'd6554;
    w_shift = 4'd9;
    capacity = 11'd100;
    avg_len = 0;
    mark_count = -1;
    pend_mark = 1'b0;
    errors = 0;
    packets = 0;
    verdicts_seen = 0;
    marks_seen = 0;
    drops_seen = 0;
    stall_left = 0;
    no_gaps = 1'b0;
    no_stalls = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_pending_mark();
    test_zero_shift();
    test_band(5, 50, 6554, 9, 100, 120);
    test_band(10, 60, 65535, 2, 70, 130);
    test_band(0, 1024, 65535, 1, 1024, 120);
    test_band(1024, 1, 20000, 15, 1, 80);
    test_band(30, 0, 0, 4, 40, 80);
    test_band(0, 1, 65535, 0, 1024, 80);
    test_band(100, 300, 16384, 5, 500, 150);
    test_pressure();
    test_band(2, 12, 50000, 3, 14, 130);

    $display("covered %0d packets over 12 register settings: %0d verdicts, %0d marks, %0d drops",
             packets, verdicts_seen, marks_seen, drops_seen);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
